### design/two_digit_date_to_epoch_seconds_defines.svh
// assertion macros shared by the date to epoch seconds modules
`ifndef TWO_DIGIT_DATE_TO_EPOCH_SECONDS_DEFINES_SVH
`define TWO_DIGIT_DATE_TO_EPOCH_SECONDS_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define TDES_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define TDES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/tdes_pkg.sv
// types, constants and calendar functions for the date to epoch seconds block
`timescale 1ns / 1ps

package tdes_pkg;

	// input word: one byte of the date string or the end marker
	typedef struct packed {
		logic       is_end;
		logic [7:0] char_byte;
	} chr_word_t;

	// result word
	typedef struct packed {
		logic signed [30:0] epoch_seconds;
		logic               bad_date;
	} res_word_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HOUR,
		ST_MIN,
		ST_SEC,
		ST_DONE
	} state_t;

	// datapath arithmetic step
	typedef enum logic [1:0] {
		OP_NONE,
		OP_HOUR,
		OP_MIN,
		OP_SEC
	} calc_op_t;

	// commands from controller to datapath
	typedef struct packed {
		logic     take_char;
		logic     take_end;
		calc_op_t op;
		logic     load_out;
	} ctrl_cmd_t;

	// field order in the string
	localparam logic [2:0] FLD_YEAR  = 3'd0;
	localparam logic [2:0] FLD_MONTH = 3'd1;
	localparam logic [2:0] FLD_DAY   = 3'd2;
	localparam logic [2:0] FLD_HOUR  = 3'd3;
	localparam logic [2:0] FLD_MIN   = 3'd4;
	localparam logic [2:0] FLD_SEC   = 3'd5;
	localparam logic [2:0] FLD_COUNT = 3'd6;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [8:0] DIGIT_BIAS = 9'd48;

	// defaults for missing fields
	localparam logic [6:0] YEAR_DEFAULT  = 7'd99;
	localparam logic [3:0] MONTH_DEFAULT = 4'd12;
	localparam logic [4:0] HOUR_DEFAULT  = 5'd23;
	localparam logic [5:0] MIN_DEFAULT   = 6'd59;
	localparam logic [5:0] SEC_DEFAULT   = 6'd59;

	localparam logic [6:0] YEAR_FIRST = 7'd70;
	localparam logic [6:0] YEAR_LAST  = 7'd99;

	localparam logic [4:0] MONTH_DAYS [0:11] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// days before the first of each month in a common year
	localparam logic [8:0] MONTH_CUM [0:11] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// days in a month, every fourth year leap; 31 for a month out of range
	function automatic logic [4:0] month_size(input logic [6:0] yy, input logic [3:0] mm);
		logic [3:0] idx;
		idx = mm - 4'd1;
		if (mm < 4'd1 || mm > 4'd12) begin
			return 5'd31;
		end else if (mm == 4'd2 && yy[1:0] == 2'b00) begin
			return 5'd29;
		end
		return MONTH_DAYS[idx];
	endfunction

	// days from january 1 to the first of the month
	function automatic logic [8:0] month_before(input logic [6:0] yy, input logic [3:0] mm);
		logic [3:0] idx;
		logic [8:0] days;
		idx = mm - 4'd1;
		if (mm < 4'd1 || mm > 4'd12) begin
			return 9'd0;
		end
		days = MONTH_CUM[idx];
		if (mm > 4'd2 && yy[1:0] == 2'b00) begin
			days = days + 9'd1;
		end
		return days;
	endfunction

	// days from 1970 to january 1 of the year
	function automatic logic [13:0] year_before(input logic [6:0] yy);
		logic [4:0] d;
		logic [5:0] d1;
		d  = 5'(yy - YEAR_FIRST);
		d1 = {1'b0, d} + 6'd1;
		if (yy < YEAR_FIRST) begin
			return 14'd0;
		end
		return 14'({9'd0, d} * 14'd365) + {10'd0, d1[5:2]};
	endfunction

endpackage

### design/tdes_ctrl.sv
// controller state machine: handshakes and sequencing of the seconds calculation
`timescale 1ns / 1ps
`include "two_digit_date_to_epoch_seconds_defines.svh"

module tdes_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               chr_valid,
	input  logic               chr_is_end,
	output logic               chr_stall,
	output logic               res_valid,
	input  logic               res_stall,
	output tdes_pkg::ctrl_cmd_t cmd
);

	tdes_pkg::state_t state_q;
	tdes_pkg::state_t state_d;
	logic             res_valid_q;
	logic             chr_take;
	logic             res_take;

	assign chr_take = chr_valid && !chr_stall;
	assign res_take = res_valid_q && !res_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tdes_pkg::ST_IDLE: begin
				if (chr_take && chr_is_end) state_d = tdes_pkg::ST_HOUR;
			end
			tdes_pkg::ST_HOUR: state_d = tdes_pkg::ST_MIN;
			tdes_pkg::ST_MIN:  state_d = tdes_pkg::ST_SEC;
			tdes_pkg::ST_SEC:  state_d = tdes_pkg::ST_DONE;
			tdes_pkg::ST_DONE: begin
				if (!res_valid_q || !res_stall) state_d = tdes_pkg::ST_IDLE;
			end
			default: state_d = tdes_pkg::ST_IDLE;
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		chr_stall     = 1'b1;
		cmd.take_char = 1'b0;
		cmd.take_end  = 1'b0;
		cmd.op        = tdes_pkg::OP_NONE;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			tdes_pkg::ST_IDLE: begin
				chr_stall     = 1'b0;
				cmd.take_char = chr_valid && !chr_is_end;
				cmd.take_end  = chr_valid && chr_is_end;
			end
			tdes_pkg::ST_HOUR: cmd.op = tdes_pkg::OP_HOUR;
			tdes_pkg::ST_MIN:  cmd.op = tdes_pkg::OP_MIN;
			tdes_pkg::ST_SEC:  cmd.op = tdes_pkg::OP_SEC;
			tdes_pkg::ST_DONE: cmd.load_out = !res_valid_q || !res_stall;
			default: chr_stall = 1'b1;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdes_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_take) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

	// a stalled result word stays on offer
	`TDES_ASSERT_NEXT(a_res_held, res_valid_q && res_stall, res_valid_q,
		"result word dropped while stalled")

	// an end word starts the calculation and blocks further input words
	`TDES_ASSERT_NEXT(a_end_busy, cmd.take_end, chr_stall && state_q == tdes_pkg::ST_HOUR,
		"end word did not start the calculation")

	// a taken result word without a new load leaves the output empty
	`TDES_ASSERT_NEXT(a_res_clear, res_take && !cmd.load_out, !res_valid_q,
		"result word repeated")

endmodule

### design/tdes_dp.sv
// datapath: field parser, range checks and the seconds multiply-add chain
`timescale 1ns / 1ps
`include "two_digit_date_to_epoch_seconds_defines.svh"

module tdes_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tdes_pkg::ctrl_cmd_t   cmd,
	input  tdes_pkg::chr_word_t   chr_word,
	input  logic                  cfg_we,
	input  logic signed [16:0]    cfg_wdata,
	output tdes_pkg::res_word_t   res_word
);

	// parse state
	logic [2:0] field_q;
	logic       await_q;
	logic [3:0] tens_q;
	logic [6:0] year_q;
	logic [3:0] month_q;
	logic [4:0] day_q;
	logic [4:0] hour_q;
	logic [5:0] min_q;
	logic [5:0] sec_q;
	logic       err_q;

	// calculation state
	logic [29:0] acc_q;
	logic [4:0]  calc_hour_q;
	logic [5:0]  calc_min_q;
	logic [5:0]  calc_sec_q;
	logic        calc_bad_q;

	logic signed [16:0]  zone_q;
	tdes_pkg::res_word_t res_word_q;

	logic [7:0]  b;
	logic [8:0]  units_sum;
	logic [8:0]  fld_val;
	logic        fld_ok;
	logic        is_digit;
	logic        char_skip;
	logic [4:0]  msize;
	logic [4:0]  day_eff;
	logic [13:0] days;
	logic signed [31:0] total;

	assign b = chr_word.char_byte;

	// field value plus the digit bias: tens * 10 + raw byte
	assign units_sum = ({5'd0, tens_q} * 9'd10) + {1'b0, b};
	assign fld_val   = units_sum - tdes_pkg::DIGIT_BIAS;
	assign is_digit  = (b >= tdes_pkg::ASCII_ZERO) && (b <= tdes_pkg::ASCII_NINE);
	assign char_skip = (b == 8'd0) || err_q || (field_q >= tdes_pkg::FLD_COUNT);
	assign msize     = tdes_pkg::month_size(year_q, month_q);

	// range check of a completed field, done on the biased sum
	always_comb begin
		unique case (field_q)
			tdes_pkg::FLD_YEAR:  fld_ok = units_sum >= 9'd118 && units_sum <= 9'd147;
			tdes_pkg::FLD_MONTH: fld_ok = units_sum >= 9'd49 && units_sum <= 9'd60;
			tdes_pkg::FLD_DAY:   fld_ok = units_sum >= 9'd49
				&& units_sum <= ({4'd0, msize} + tdes_pkg::DIGIT_BIAS);
			tdes_pkg::FLD_HOUR:  fld_ok = units_sum >= 9'd48 && units_sum <= 9'd71;
			tdes_pkg::FLD_MIN:   fld_ok = units_sum >= 9'd48 && units_sum <= 9'd107;
			tdes_pkg::FLD_SEC:   fld_ok = units_sum >= 9'd48 && units_sum <= 9'd107;
			default:             fld_ok = 1'b0;
		endcase
	end

	// days since 1970 up to the start of the day
	assign day_eff = (day_q == 5'd0) ? msize : day_q;
	assign days    = tdes_pkg::year_before(year_q)
		+ {5'd0, tdes_pkg::month_before(year_q, month_q)}
		+ {9'd0, day_eff} - 14'd1;

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= tdes_pkg::FLD_YEAR;
			await_q <= 1'b0;
			tens_q  <= 4'd0;
			year_q  <= tdes_pkg::YEAR_DEFAULT;
			month_q <= tdes_pkg::MONTH_DEFAULT;
			day_q   <= 5'd0;
			hour_q  <= tdes_pkg::HOUR_DEFAULT;
			min_q   <= tdes_pkg::MIN_DEFAULT;
			sec_q   <= tdes_pkg::SEC_DEFAULT;
			err_q   <= 1'b0;
		end else if (cmd.take_end) begin
			field_q <= tdes_pkg::FLD_YEAR;
			await_q <= 1'b0;
			tens_q  <= 4'd0;
			year_q  <= tdes_pkg::YEAR_DEFAULT;
			month_q <= tdes_pkg::MONTH_DEFAULT;
			day_q   <= 5'd0;
			hour_q  <= tdes_pkg::HOUR_DEFAULT;
			min_q   <= tdes_pkg::MIN_DEFAULT;
			sec_q   <= tdes_pkg::SEC_DEFAULT;
			err_q   <= 1'b0;
		end else if (cmd.take_char && !char_skip) begin
			if (await_q) begin
				await_q <= 1'b0;
				field_q <= field_q + 3'd1;
				if (!fld_ok) begin
					err_q <= 1'b1;
				end else begin
					case (field_q)
						tdes_pkg::FLD_YEAR:  year_q  <= fld_val[6:0];
						tdes_pkg::FLD_MONTH: month_q <= fld_val[3:0];
						tdes_pkg::FLD_DAY:   day_q   <= fld_val[4:0];
						tdes_pkg::FLD_HOUR:  hour_q  <= fld_val[4:0];
						tdes_pkg::FLD_MIN:   min_q   <= fld_val[5:0];
						default:             sec_q   <= fld_val[5:0];
					endcase
				end
			end else if (is_digit) begin
				tens_q  <= 4'(b - tdes_pkg::ASCII_ZERO);
				await_q <= 1'b1;
			end
		end
	end

	// multiply-add chain, one constant multiply per cycle
	always_ff @(posedge clk) begin
		if (cmd.take_end) begin
			acc_q       <= {16'd0, days};
			calc_hour_q <= hour_q;
			calc_min_q  <= min_q;
			calc_sec_q  <= sec_q;
			calc_bad_q  <= err_q || await_q;
		end else begin
			case (cmd.op)
				tdes_pkg::OP_HOUR: acc_q <= 30'(acc_q * 30'd24) + {25'd0, calc_hour_q};
				tdes_pkg::OP_MIN:  acc_q <= 30'(acc_q * 30'd60) + {24'd0, calc_min_q};
				tdes_pkg::OP_SEC:  acc_q <= 30'(acc_q * 30'd60) + {24'd0, calc_sec_q};
				default:           acc_q <= acc_q;
			endcase
		end
	end

	// zone offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= 17'sd0;
		end else if (cfg_we) begin
			zone_q <= cfg_wdata;
		end
	end

	// zone offset added as the result word is loaded
	assign total = $signed({2'b00, acc_q}) + $signed({{15{zone_q[16]}}, zone_q});

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_word_q.epoch_seconds <= calc_bad_q ? 31'sd0 : total[30:0];
			res_word_q.bad_date      <= calc_bad_q;
		end
	end

	assign res_word = res_word_q;

	// a stored year is always in the two-digit window
	`TDES_ASSERT_NOW(a_year_range, 1'b1,
		year_q >= tdes_pkg::YEAR_FIRST && year_q <= tdes_pkg::YEAR_LAST,
		"stored year out of range")

	// a stored month is always a real month
	`TDES_ASSERT_NOW(a_month_range, 1'b1, month_q >= 4'd1 && month_q <= 4'd12,
		"stored month out of range")

	// the field counter never runs past the last field
	`TDES_ASSERT_NOW(a_field_limit, 1'b1, field_q <= tdes_pkg::FLD_COUNT,
		"field counter overran")

endmodule

### design/two_digit_date_to_epoch_seconds.sv
// Two-digit date string to seconds since 1970, top level.
//
// The string comes in on the chr channel one byte per word, closed by a word
// with is_end set. Fields are year (70-99), month, day, hour, minute, second,
// two characters each; non-digits before a field's first digit are skipped.
// Character words are taken while the block is idle. An end word starts a
// multiply-add sequence (days, then times 24, 60 and 60, then the zone add)
// through the HOUR, MIN, SEC and DONE states; the result word is then offered
// on the res channel, and chr_stall is high until it is loaded.
// A result word waits in an output register while res_stall is high; new
// character words are still taken then, and a following end word is held in
// its last step until the output register is free.
// cfg_we writes cfg_wdata, the zone offset in seconds, added to every good result;
// write it only while the block is idle.
// Reset clears the parser to its defaults, the zone offset to zero and the
// result channel to empty.
`timescale 1ns / 1ps

module two_digit_date_to_epoch_seconds (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                chr_valid,
	output logic                chr_stall,
	input  tdes_pkg::chr_word_t chr_word,
	output logic                res_valid,
	input  logic                res_stall,
	output tdes_pkg::res_word_t res_word,
	input  logic                cfg_we,
	input  logic signed [16:0]  cfg_wdata
);

	tdes_pkg::ctrl_cmd_t cmd;

	// sequencing and handshakes
	tdes_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.chr_valid  (chr_valid),
		.chr_is_end (chr_word.is_end),
		.chr_stall  (chr_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.cmd        (cmd)
	);

	// parser and arithmetic
	tdes_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.chr_word  (chr_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_word  (res_word)
	);

endmodule

### sim/tb_top.sv
// testbench for the two-digit date to epoch seconds block
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_WORDS   = 250;
	localparam int REPORT_LIMIT  = 10;
	localparam int NUM_PHASES    = 6;

	// directed table: expected value typed in, or one of these markers
	localparam int FROM_MODEL = -1;
	localparam int BAD_STRING = -2;
	localparam int NUM_CASES  = 11;

	// '@' in a case string stands for a zero byte
	string case_text [NUM_CASES] = '{
		"",
		"700101000000",
		"7",
		"69",
		"7\377",
		"7@0",
		"x9613",
		"960229",
		"970229",
		"7a",
		"99123123595999"
	};
	int case_expect [NUM_CASES] = '{
		946684799,
		0,
		BAD_STRING,
		BAD_STRING,
		BAD_STRING,
		FROM_MODEL,
		BAD_STRING,
		FROM_MODEL,
		BAD_STRING,
		BAD_STRING,
		946684799
	};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                chr_valid = 1'b0;
	logic                chr_stall;
	tdes_pkg::chr_word_t chr_word  = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	tdes_pkg::res_word_t res_word;
	logic                cfg_we    = 1'b0;
	logic signed [16:0]  cfg_wdata = '0;

	two_digit_date_to_epoch_seconds dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr_word  (chr_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// parser state mirrored by the date predictor
	int                 fld_idx;
	bit                 want_units;
	int                 tens_val;
	int                 yr_val, mon_val, day_val, hr_val, min_val, sec_val;
	bit                 parse_err;
	logic signed [16:0] zone_now = '0;

	tdes_pkg::res_word_t expected_results [$];
	bit                  have_typed = 1'b0;
	tdes_pkg::res_word_t typed_result;
	logic [7:0]          str_bytes [$];

	int words_sent  = 0;
	int fault_count = 0;
	int cycle_count = 0;
	int stall_left  = 0;
	bit idle_allowed = 1'b1;
	bit quiet        = 1'b0;

	// days in a month, every fourth year leap
	function automatic int month_len(int yy, int mm);
		if (mm < 1 || mm > 12) begin
			return 31;
		end
		case (mm)
			2: begin
				return (yy % 4 == 0) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	task automatic clear_parse();
		fld_idx    = tdes_pkg::FLD_YEAR;
		want_units = 1'b0;
		tens_val   = 0;
		yr_val     = tdes_pkg::YEAR_DEFAULT;
		mon_val    = tdes_pkg::MONTH_DEFAULT;
		day_val    = 0;
		hr_val     = tdes_pkg::HOUR_DEFAULT;
		min_val    = tdes_pkg::MIN_DEFAULT;
		sec_val    = tdes_pkg::SEC_DEFAULT;
		parse_err  = 1'b0;
	endtask

	// range check of a completed field
	task automatic store_field(int v);
		case (fld_idx)
			tdes_pkg::FLD_YEAR: begin
				if (v < 70 || v > 99) parse_err = 1'b1; else yr_val = v;
			end
			tdes_pkg::FLD_MONTH: begin
				if (v < 1 || v > 12) parse_err = 1'b1; else mon_val = v;
			end
			tdes_pkg::FLD_DAY: begin
				if (v < 1 || v > month_len(yr_val, mon_val)) parse_err = 1'b1;
				else day_val = v;
			end
			tdes_pkg::FLD_HOUR: begin
				if (v < 0 || v > 23) parse_err = 1'b1; else hr_val = v;
			end
			tdes_pkg::FLD_MIN: begin
				if (v < 0 || v > 59) parse_err = 1'b1; else min_val = v;
			end
			default: begin
				if (v < 0 || v > 59) parse_err = 1'b1; else sec_val = v;
			end
		endcase
		fld_idx++;
	endtask

	// date predictor: one accepted character or end word
	task automatic predict_date_word(tdes_pkg::chr_word_t w);
		longint              t;
		int                  dd;
		int                  b;
		bit                  bad;
		tdes_pkg::res_word_t e;
		b = int'(w.char_byte);
		if (!w.is_end) begin
			if (b != 0 && !parse_err && fld_idx < tdes_pkg::FLD_COUNT) begin
				if (want_units) begin
					want_units = 1'b0;
					store_field(tens_val * 10 + b - 48);
				end else if (b >= tdes_pkg::ASCII_ZERO && b <= tdes_pkg::ASCII_NINE) begin
					tens_val   = b - tdes_pkg::ASCII_ZERO;
					want_units = 1'b1;
				end
			end
		end else begin
			bad = parse_err || want_units;
			t = 0;
			if (!bad) begin
				dd = (day_val != 0) ? day_val : month_len(yr_val, mon_val);
				for (int y = 70; y < yr_val; y++) t += (y % 4 != 0) ? 365 : 366;
				for (int m = 1; m < mon_val; m++) t += month_len(yr_val, m);
				t += dd - 1;
				t = t * 24 + hr_val;
				t = t * 60 + min_val;
				t = t * 60 + sec_val;
				t += zone_now;
			end
			e.epoch_seconds = bad ? '0 : t[30:0];
			e.bad_date      = bad;
			if (have_typed) begin
				e          = typed_result;
				have_typed = 1'b0;
			end
			expected_results.push_back(e);
			clear_parse();
		end
	endtask

	// offer one word, hold it until taken
	task automatic send_word(tdes_pkg::chr_word_t w);
		int gap;
		gap = 0;
		if (idle_allowed && !quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
		if (gap > 0) begin
			chr_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chr_valid <= 1'b1;
		chr_word  <= w;
		@(posedge clk);
		while (chr_stall !== 1'b0) @(posedge clk);
		predict_date_word(w);
		words_sent++;
	endtask

	// string bytes, then the end word with a junk character
	task automatic send_string();
		tdes_pkg::chr_word_t w;
		foreach (str_bytes[i]) begin
			w.is_end    = 1'b0;
			w.char_byte = str_bytes[i];
			send_word(w);
		end
		w.is_end    = 1'b1;
		w.char_byte = 8'($urandom);
		send_word(w);
	endtask

	// stop sending until every result is back and the block is quiet
	task automatic drain_results();
		chr_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_zone(logic signed [16:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		zone_now   = v;
	endtask

	// separator byte: any non-digit, sometimes a zero byte
	function automatic logic [7:0] random_separator();
		logic [7:0] b;
		if ($urandom_range(0, 9) == 0) begin
			return 8'h00;
		end
		do b = 8'($urandom_range(1, 255));
		while (b >= tdes_pkg::ASCII_ZERO && b <= tdes_pkg::ASCII_NINE);
		return b;
	endfunction

	// mostly well-formed dates, some broken ones, some noise
	task automatic build_date_string();
		int kind, nf, flaw, target, lo, hi, y, m;
		int vals [6];
		str_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind >= 88) begin
			repeat ($urandom_range(0, 16)) begin
				if ($urandom_range(0, 2) == 0)
					str_bytes.push_back(8'(tdes_pkg::ASCII_ZERO + $urandom_range(0, 9)));
				else
					str_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			nf = $urandom_range(0, 9);
			if (nf > 6) nf = 6;
			y = tdes_pkg::YEAR_DEFAULT;
			m = tdes_pkg::MONTH_DEFAULT;
			for (int i = 0; i < nf; i++) begin
				case (i)
					tdes_pkg::FLD_YEAR:  begin lo = 70; hi = 99; end
					tdes_pkg::FLD_MONTH: begin lo = 1;  hi = 12; end
					tdes_pkg::FLD_DAY:   begin lo = 1;  hi = month_len(y, m); end
					tdes_pkg::FLD_HOUR:  begin lo = 0;  hi = 23; end
					default:             begin lo = 0;  hi = 59; end
				endcase
				vals[i] = $urandom_range(hi, lo);
				if (i == tdes_pkg::FLD_YEAR) y = vals[i];
				if (i == tdes_pkg::FLD_MONTH) m = vals[i];
			end
			flaw   = (kind >= 70) ? $urandom_range(0, 3) : -1;
			target = (nf > 0) ? $urandom_range(0, nf - 1) : 0;
			// out-of-range value in one field
			if (flaw == 0 && nf > 0) vals[target] = $urandom_range(0, 99);
			for (int i = 0; i < nf; i++) begin
				repeat ($urandom_range(0, 2)) str_bytes.push_back(random_separator());
				str_bytes.push_back(8'(tdes_pkg::ASCII_ZERO + vals[i] / 10));
				// raw units byte in one field
				if (flaw == 1 && i == target)
					str_bytes.push_back(8'($urandom_range(0, 255)));
				else
					str_bytes.push_back(8'(tdes_pkg::ASCII_ZERO + vals[i] % 10));
			end
			// lone trailing digit
			if (flaw == 2)
				str_bytes.push_back(8'(tdes_pkg::ASCII_ZERO + $urandom_range(0, 9)));
			// trailing extra bytes
			if (flaw == 3) begin
				repeat ($urandom_range(1, 6)) str_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic report_fault(string what, tdes_pkg::res_word_t want,
			tdes_pkg::res_word_t got);
		if (fault_count < REPORT_LIMIT)
			$display("%0t %s: expected secs=%0d bad=%0b, got secs=%0d bad=%0b", $time, what,
				want.epoch_seconds, want.bad_date, got.epoch_seconds, got.bad_date);
		fault_count++;
	endtask

	// result side: compare each taken word, random stall bursts
	always @(posedge clk) begin
		tdes_pkg::res_word_t want;
		if (res_valid === 1'b1 && res_stall == 1'b0) begin
			if (expected_results.size() == 0) begin
				report_fault("unexpected result", '0, res_word);
			end else begin
				want = expected_results.pop_front();
				if (res_word.epoch_seconds !== want.epoch_seconds ||
						res_word.bad_date !== want.bad_date)
					report_fault("result mismatch", want, res_word);
			end
		end
		if (stall_left == 0 && idle_allowed && !quiet && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 19);
		res_stall <= (stall_left > 0);
		if (stall_left > 0) stall_left--;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// reset, directed table, then random phases over several zone offsets
	initial begin
		string              txt;
		int                 start;
		logic signed [16:0] zones [NUM_PHASES];
		clear_parse();
		zones[0] = -17'sd50400;
		zones[1] = 17'sd43200;
		zones[2] = 17'($urandom_range(0, 93600) - 50400);
		zones[3] = -17'sd1;
		zones[4] = 17'($urandom_range(0, 93600) - 50400);
		zones[5] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings at the reset zone offset
		for (int c = 0; c < NUM_CASES; c++) begin
			txt = case_text[c];
			str_bytes.delete();
			for (int k = 0; k < txt.len(); k++)
				str_bytes.push_back((txt[k] == "@") ? 8'h00 : 8'(txt[k]));
			if (case_expect[c] != FROM_MODEL) begin
				have_typed                 = 1'b1;
				typed_result.bad_date      = (case_expect[c] == BAD_STRING);
				typed_result.epoch_seconds = typed_result.bad_date ? '0 : 31'(case_expect[c]);
			end
			send_string();
		end
		drain_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_zone(zones[p]);
			// last phase runs with no random input gaps or result stall bursts
			idle_allowed = (p != NUM_PHASES - 1);
			quiet        = 1'b0;
			start        = words_sent;
			while (words_sent - start < PHASE_WORDS) begin
				if ($urandom_range(0, 19) == 0) quiet = !quiet;
				build_date_string();
				send_string();
				if ($urandom_range(0, 14) == 0) drain_results();
			end
			drain_results();
		end

		if (fault_count == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/tdes_pkg.sv
design/tdes_ctrl.sv
design/tdes_dp.sv
design/two_digit_date_to_epoch_seconds.sv
sim/tb_top.sv
